/* src/tmdsr_pkg.sv */
package tmdsr_pkg;

    // Field widths
    localparam int unsigned PowerW  = 8;
    localparam int unsigned TicksW  = 23;
    localparam int unsigned CountW  = 24;
    localparam int unsigned CfgW    = 16;
    localparam int unsigned CfgIdxW = 2;

    // Largest magnitude kept from an encoder count
    localparam logic [TicksW-1:0] MagMax = {TicksW{1'b1}};

    // Request kinds
    localparam logic MODE_START = 1'b0;
    localparam logic MODE_TICK  = 1'b1;

    // Configuration register indexes
    localparam logic [CfgIdxW-1:0] CFG_CHECK_INTERVAL = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_MIN_PROGRESS   = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_PAUSE_TIME     = 2'd2;
    localparam logic [CfgIdxW-1:0] CFG_SETTLE_TIME    = 2'd3;

    // Configuration reset values
    localparam logic [CfgW-1:0] RST_CHECK_INTERVAL = 16'd250;
    localparam logic [CfgW-1:0] RST_MIN_PROGRESS   = 16'd36;
    localparam logic [CfgW-1:0] RST_PAUSE_TIME     = 16'd500;
    localparam logic [CfgW-1:0] RST_SETTLE_TIME    = 16'd200;

    // Phase codes
    typedef logic [1:0] t_phase;
    localparam t_phase PH_IDLE   = 2'd0;
    localparam t_phase PH_DRIVE  = 2'd1;
    localparam t_phase PH_PAUSE  = 2'd2;
    localparam t_phase PH_SETTLE = 2'd3;

    // One result item
    typedef struct packed {
        logic signed [PowerW-1:0] left_drive;
        logic signed [PowerW-1:0] right_drive;
        logic                     clear_encoders;
        logic                     busy_res;
        logic                     stall_pause;
        logic                     done_res;
    } t_result;

endpackage

/* src/tmdsr_if.sv */
// Input request channel
interface tmdsr_cmd_if;
    logic                                       valid;
    logic                                       ready;
    logic                                       mode;
    logic signed [tmdsr_pkg::PowerW-1:0]        left_power;
    logic signed [tmdsr_pkg::PowerW-1:0]        right_power;
    logic        [tmdsr_pkg::TicksW-1:0]        target_ticks;
    logic signed [tmdsr_pkg::CountW-1:0]        left_count;
    logic signed [tmdsr_pkg::CountW-1:0]        right_count;

    modport source (output valid, mode, left_power, right_power, target_ticks,
                    left_count, right_count, input ready);
    modport sink   (input valid, mode, left_power, right_power, target_ticks,
                    left_count, right_count, output ready);
endinterface

// Result channel
interface tmdsr_res_if;
    logic                                valid;
    logic                                ready;
    logic signed [tmdsr_pkg::PowerW-1:0] left_drive;
    logic signed [tmdsr_pkg::PowerW-1:0] right_drive;
    logic                                clear_encoders;
    logic                                busy_res;
    logic                                stall_pause;
    logic                                done_res;

    modport source (output valid, left_drive, right_drive, clear_encoders, busy_res,
                    stall_pause, done_res, input ready);
    modport sink   (input valid, left_drive, right_drive, clear_encoders, busy_res,
                    stall_pause, done_res, output ready);
endinterface

// Configuration write channel
interface tmdsr_cfg_if;
    logic                                 valid;
    logic                                 ready;
    logic [tmdsr_pkg::CfgIdxW-1:0]        index;
    logic [tmdsr_pkg::CfgW-1:0]           data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* src/two_motor_distance_drive_stall_retry_top.sv */
// Channel   Direction  Carries
// i_cmd     in         start (powers, target) or tick (encoder counts)
// o_res     out        drive powers, encoder clear, busy, stall and done flags
// i_cfg     in         register index and 16-bit write data
//
// Each request is handled as it is taken: the drive state and the result
// register update at the edge on which the request is taken.
// A new request is taken every cycle while the result register is empty
// or its contents are being taken in the same cycle.
// Configuration writes are always taken.
// Synchronous active-low reset returns the block to idle with the default
// configuration; no clearing pass is needed.
module two_motor_distance_drive_stall_retry_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tmdsr_cmd_if.sink   i_cmd,
    tmdsr_res_if.source o_res,
    tmdsr_cfg_if.sink   i_cfg
);

    // Configuration registers
    logic [tmdsr_pkg::CfgW-1:0]   r_check_interval;
    logic [tmdsr_pkg::CfgW-1:0]   r_min_progress;
    logic [tmdsr_pkg::CfgW-1:0]   r_pause_time;
    logic [tmdsr_pkg::CfgW-1:0]   r_settle_time;

    // Drive state
    tmdsr_pkg::t_phase                    r_phase, n_phase;
    logic [tmdsr_pkg::PowerW-1:0]         r_saved_left, n_saved_left;
    logic [tmdsr_pkg::PowerW-1:0]         r_saved_right, n_saved_right;
    logic                                 r_left_en, n_left_en;
    logic                                 r_right_en, n_right_en;
    logic [tmdsr_pkg::TicksW-1:0]         r_goal, n_goal;
    logic [tmdsr_pkg::TicksW-1:0]         r_last_left, n_last_left;
    logic [tmdsr_pkg::TicksW-1:0]         r_last_right, n_last_right;
    logic [tmdsr_pkg::CfgW-1:0]           r_elapsed, n_elapsed;

    // Result register
    logic                                 r_res_valid;
    tmdsr_pkg::t_result                   r_res, n_res;

    logic                                 cmd_take;
    logic [tmdsr_pkg::CountW-1:0]         left_abs, right_abs;
    logic [tmdsr_pkg::TicksW-1:0]         left_mag, right_mag;
    logic [tmdsr_pkg::TicksW-1:0]         left_diff, right_diff;
    logic [tmdsr_pkg::TicksW-1:0]         min_ext;
    logic [tmdsr_pkg::CfgW-1:0]           elapsed_inc;
    logic                                 left_reached, right_reached;
    logic                                 left_stall, right_stall;

    // Handshakes
    assign i_cfg.ready = 1'b1;
    assign i_cmd.ready = !r_res_valid || o_res.ready;
    assign cmd_take    = i_cmd.valid && i_cmd.ready;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_check_interval <= tmdsr_pkg::RST_CHECK_INTERVAL;
            r_min_progress   <= tmdsr_pkg::RST_MIN_PROGRESS;
            r_pause_time     <= tmdsr_pkg::RST_PAUSE_TIME;
            r_settle_time    <= tmdsr_pkg::RST_SETTLE_TIME;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                tmdsr_pkg::CFG_CHECK_INTERVAL: r_check_interval <= i_cfg.data;
                tmdsr_pkg::CFG_MIN_PROGRESS:   r_min_progress   <= i_cfg.data;
                tmdsr_pkg::CFG_PAUSE_TIME:     r_pause_time     <= i_cfg.data;
                tmdsr_pkg::CFG_SETTLE_TIME:    r_settle_time    <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // Count magnitudes, saturated so that the most negative count fits.
    assign left_abs  = i_cmd.left_count[tmdsr_pkg::CountW-1]
                       ? (~i_cmd.left_count + 1'b1) : i_cmd.left_count;
    assign right_abs = i_cmd.right_count[tmdsr_pkg::CountW-1]
                       ? (~i_cmd.right_count + 1'b1) : i_cmd.right_count;
    assign left_mag  = left_abs[tmdsr_pkg::CountW-1]
                       ? tmdsr_pkg::MagMax : left_abs[tmdsr_pkg::TicksW-1:0];
    assign right_mag = right_abs[tmdsr_pkg::CountW-1]
                       ? tmdsr_pkg::MagMax : right_abs[tmdsr_pkg::TicksW-1:0];

    // Progress since the last check, in either direction
    assign left_diff  = (left_mag >= r_last_left) ? left_mag - r_last_left
                                                  : r_last_left - left_mag;
    assign right_diff = (right_mag >= r_last_right) ? right_mag - r_last_right
                                                    : r_last_right - right_mag;
    assign min_ext    = {{(tmdsr_pkg::TicksW - tmdsr_pkg::CfgW){1'b0}}, r_min_progress};

    assign left_reached  = left_mag >= r_goal;
    assign right_reached = right_mag >= r_goal;
    assign left_stall    = !left_reached && r_left_en && (left_diff < min_ext);
    assign right_stall   = !right_reached && r_right_en && (right_diff < min_ext);

    // Millisecond counter stops at its top value.
    assign elapsed_inc = (&r_elapsed) ? r_elapsed : r_elapsed + 1'b1;

    // Next state and result for the request on the input
    always_comb begin
        n_phase       = r_phase;
        n_saved_left  = r_saved_left;
        n_saved_right = r_saved_right;
        n_left_en     = r_left_en;
        n_right_en    = r_right_en;
        n_goal        = r_goal;
        n_last_left   = r_last_left;
        n_last_right  = r_last_right;
        n_elapsed     = r_elapsed;
        n_res         = '0;

        if (i_cmd.mode == tmdsr_pkg::MODE_START) begin
            n_saved_left         = i_cmd.left_power;
            n_saved_right        = i_cmd.right_power;
            n_goal               = i_cmd.target_ticks;
            n_left_en            = i_cmd.left_power != '0;
            n_right_en           = i_cmd.right_power != '0;
            n_last_left          = '0;
            n_last_right         = '0;
            n_elapsed            = '0;
            n_phase              = tmdsr_pkg::PH_DRIVE;
            n_res.left_drive     = i_cmd.left_power;
            n_res.right_drive    = i_cmd.right_power;
            n_res.clear_encoders = 1'b1;
            n_res.busy_res       = 1'b1;
        end else begin
            unique case (r_phase)
                tmdsr_pkg::PH_DRIVE: begin
                    n_res.busy_res = 1'b1;
                    if (left_reached) begin
                        n_left_en = 1'b0;
                    end
                    if (right_reached) begin
                        n_right_en = 1'b0;
                    end
                    if (left_reached && right_reached) begin
                        n_elapsed = '0;
                        if (r_settle_time == '0) begin
                            n_phase        = tmdsr_pkg::PH_IDLE;
                            n_res.busy_res = 1'b0;
                            n_res.done_res = 1'b1;
                        end else begin
                            n_phase = tmdsr_pkg::PH_SETTLE;
                        end
                    end else begin
                        n_elapsed = elapsed_inc;
                        if (elapsed_inc >= r_check_interval) begin
                            n_last_left  = left_mag;
                            n_last_right = right_mag;
                            n_elapsed    = '0;
                            if (left_stall || right_stall) begin
                                n_phase           = tmdsr_pkg::PH_PAUSE;
                                n_res.stall_pause = 1'b1;
                            end
                        end
                        if (n_phase == tmdsr_pkg::PH_DRIVE) begin
                            n_res.left_drive  = n_left_en ? r_saved_left : '0;
                            n_res.right_drive = n_right_en ? r_saved_right : '0;
                        end
                    end
                end
                tmdsr_pkg::PH_PAUSE: begin
                    n_res.busy_res = 1'b1;
                    n_elapsed      = elapsed_inc;
                    if (elapsed_inc >= r_pause_time) begin
                        n_phase           = tmdsr_pkg::PH_DRIVE;
                        n_elapsed         = '0;
                        n_res.left_drive  = r_left_en ? r_saved_left : '0;
                        n_res.right_drive = r_right_en ? r_saved_right : '0;
                    end else begin
                        n_res.stall_pause = 1'b1;
                    end
                end
                tmdsr_pkg::PH_SETTLE: begin
                    n_res.busy_res = 1'b1;
                    n_elapsed      = elapsed_inc;
                    if (elapsed_inc >= r_settle_time) begin
                        n_phase        = tmdsr_pkg::PH_IDLE;
                        n_res.busy_res = 1'b0;
                        n_res.done_res = 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // State update on each taken request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= tmdsr_pkg::PH_IDLE;
            r_saved_left  <= '0;
            r_saved_right <= '0;
            r_left_en     <= 1'b0;
            r_right_en    <= 1'b0;
            r_goal        <= '0;
            r_last_left   <= '0;
            r_last_right  <= '0;
            r_elapsed     <= '0;
        end else if (cmd_take) begin
            r_phase       <= n_phase;
            r_saved_left  <= n_saved_left;
            r_saved_right <= n_saved_right;
            r_left_en     <= n_left_en;
            r_right_en    <= n_right_en;
            r_goal        <= n_goal;
            r_last_left   <= n_last_left;
            r_last_right  <= n_last_right;
            r_elapsed     <= n_elapsed;
        end
    end

    // Result register valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (cmd_take) begin
            r_res_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_res_valid <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (cmd_take) begin
            r_res <= n_res;
        end
    end

    assign o_res.valid          = r_res_valid;
    assign o_res.left_drive     = r_res.left_drive;
    assign o_res.right_drive    = r_res.right_drive;
    assign o_res.clear_encoders = r_res.clear_encoders;
    assign o_res.busy_res       = r_res.busy_res;
    assign o_res.stall_pause    = r_res.stall_pause;
    assign o_res.done_res       = r_res.done_res;

    // A start request always leaves the block driving.
    a_start_drives: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd_take && i_cmd.mode == tmdsr_pkg::MODE_START)
            |=> (r_phase == tmdsr_pkg::PH_DRIVE))
        else $error("start request did not enter the drive phase");

    // The stall flag of a result matches a pause left behind by that request.
    a_stall_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_take |=> (r_res.stall_pause == (r_phase == tmdsr_pkg::PH_PAUSE)))
        else $error("stall flag disagrees with the pause phase");

    // Done is reported only as the block returns to idle.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_take |=> (!r_res.done_res || (r_phase == tmdsr_pkg::PH_IDLE
                                          && !r_res.busy_res)))
        else $error("done reported while a move is still running");

endmodule
